// ===== design/bde_pkg.sv =====
// Package for the binary to decimal digit emitter.
// Holds item types, the converter state type, constants and the emitter load struct.
// Used by every module in the design folder.
`default_nettype none
package bde_pkg;

	localparam int VALUE_W         = 64;
	localparam int COUNT_W         = 5;
	localparam int CHAR_W          = 6;
	localparam int BCD_W           = 4;
	localparam int MAX_DIGITS_DEF  = 20;
	localparam int MIN_NEG_DIGITS  = 19;
	localparam int POS_W           = 5;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               signed_mode;
		logic [COUNT_W-1:0] digit_count;
	} req_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last_digit;
	} rsp_item_t;

	typedef enum logic [1:0] {
		CV_IDLE,
		CV_RUN,
		CV_HOLD
	} conv_state_t;

	typedef struct packed {
		logic             load;
		logic [POS_W-1:0] last_pos;
	} emit_load_t;

endpackage
`default_nettype wire

// ===== design/bde_cell.sv =====
// One BCD digit cell of the shift-add-3 conversion chain.
// Takes a bit from its lower neighbor and hands its top bit to the next cell.
// Depends on bde_pkg.
`default_nettype none
module bde_cell (
	input  wire logic                         clk,
	input  wire logic                         clr,
	input  wire logic                         en,
	input  wire logic                         carry_in,
	output logic                              carry_out,
	output logic [bde_pkg::BCD_W-1:0]         digit
);

	logic [bde_pkg::BCD_W-1:0] digit_q;
	logic [bde_pkg::BCD_W-1:0] adj;

	always_comb begin
		if (digit_q >= 4'd5) begin
			adj = digit_q + 4'd3;
		end else begin
			adj = digit_q;
		end
	end

	assign carry_out = adj[bde_pkg::BCD_W-1];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		if (clr) begin
			digit_q <= '0;
		end else if (en) begin
			digit_q <= {adj[bde_pkg::BCD_W-2:0], carry_in};
		end
	end

endmodule
`default_nettype wire

// ===== design/bde_emit.sv =====
// Digit emitter: holds one converted number and sends its digits, most significant first.
// Loaded from the cell chain so that the next conversion can run meanwhile.
// Depends on bde_pkg.
`default_nettype none
module bde_emit #(
	parameter int NCELLS = bde_pkg::MIN_NEG_DIGITS
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire bde_pkg::emit_load_t                     ld,
	input  wire logic [NCELLS-1:0][bde_pkg::BCD_W-1:0]   digits,
	output logic                                         busy,
	output logic                                         rsp_valid,
	input  wire logic                                    rsp_stall,
	output bde_pkg::rsp_item_t                           rsp
);

	localparam int IDX_W = $clog2(NCELLS);

	logic [NCELLS-1:0][bde_pkg::BCD_W-1:0] digit_q;
	logic [IDX_W-1:0]                      pos_q;
	logic                                  busy_q;
	logic                                  take;

	assign take      = busy_q && !rsp_stall;
	assign busy      = busy_q;
	assign rsp_valid = busy_q;

	always_comb begin
		rsp.digit_char = bde_pkg::ASCII_ZERO
			+ {{(bde_pkg::CHAR_W-bde_pkg::BCD_W){1'b0}}, digit_q[pos_q]};
		rsp.last_digit = (pos_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (ld.load) begin
			busy_q <= 1'b1;
			pos_q  <= ld.last_pos[IDX_W-1:0];
		end else if (take) begin
			if (pos_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			digit_q <= digits;
		end
	end

endmodule
`default_nettype wire

// ===== design/binary_to_decimal_digit_emitter_core.sv =====
// Binary to decimal digit emitter, top level: magnitude shift register, cell chain, emitter.
// An item is shifted into the cell chain one value bit at a time, then handed to the emitter from the hold state.
// Its digits leave one per cycle while rsp_stall is low, overlapped with the next item's conversion.
// A new item is taken only once the previous one has been handed to the emitter.
// Reset clears all control state; the cells and digit store hold no reset.
`default_nettype none
module binary_to_decimal_digit_emitter_core #(
	parameter int MAX_DIGITS = bde_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire bde_pkg::req_item_t  req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output bde_pkg::rsp_item_t       rsp
);

	localparam int NCELLS = (MAX_DIGITS > bde_pkg::MIN_NEG_DIGITS) ?
		MAX_DIGITS : bde_pkg::MIN_NEG_DIGITS;
	localparam int STEP_W = $clog2(bde_pkg::VALUE_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(bde_pkg::VALUE_W - 1);

	bde_pkg::conv_state_t state_q, state_d;
	logic [STEP_W-1:0]              step_q;
	logic [bde_pkg::VALUE_W-1:0]    mag_q;
	logic [bde_pkg::POS_W-1:0]      last_pos_q;
	logic                           accept;
	logic                           cell_en;
	logic                           emit_busy;
	bde_pkg::emit_load_t            ld;
	logic [NCELLS-1:0]              carry;
	logic [NCELLS-1:0][bde_pkg::BCD_W-1:0] digits;

	logic                           neg;
	logic                           min_neg;
	logic [bde_pkg::VALUE_W-1:0]    mag_d;
	logic [bde_pkg::POS_W-1:0]      last_pos_d;

	always_comb begin
		neg     = req.signed_mode && req.value[bde_pkg::VALUE_W-1];
		min_neg = neg && (req.value == {1'b1, {(bde_pkg::VALUE_W-1){1'b0}}});
		mag_d   = neg ? (~req.value + 1'b1) : req.value;
		if (min_neg) begin
			last_pos_d = bde_pkg::POS_W'(bde_pkg::MIN_NEG_DIGITS - 1);
		end else if (req.digit_count == '0) begin
			last_pos_d = '0;
		end else if (32'(req.digit_count) > MAX_DIGITS) begin
			last_pos_d = bde_pkg::POS_W'(MAX_DIGITS - 1);
		end else begin
			last_pos_d = bde_pkg::POS_W'(req.digit_count - 1'b1);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bde_pkg::CV_IDLE: begin
				if (req_valid) begin
					state_d = bde_pkg::CV_RUN;
				end
			end
			bde_pkg::CV_RUN: begin
				if (step_q == STEP_LAST) begin
					state_d = bde_pkg::CV_HOLD;
				end
			end
			bde_pkg::CV_HOLD: begin
				if (!emit_busy) begin
					state_d = bde_pkg::CV_IDLE;
				end
			end
			default: state_d = bde_pkg::CV_IDLE;
		endcase
	end

	always_comb begin
		req_stall   = 1'b1;
		cell_en     = 1'b0;
		ld.load     = 1'b0;
		ld.last_pos = last_pos_q;
		unique case (state_q)
			bde_pkg::CV_IDLE: req_stall = 1'b0;
			bde_pkg::CV_RUN:  cell_en = 1'b1;
			bde_pkg::CV_HOLD: ld.load = !emit_busy;
			default: req_stall = 1'b1;
		endcase
	end

	assign accept = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bde_pkg::CV_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
			end else if (cell_en) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q      <= mag_d;
			last_pos_q <= last_pos_d;
		end else if (cell_en) begin
			mag_q <= {mag_q[bde_pkg::VALUE_W-2:0], 1'b0};
		end
	end

	for (genvar i = 0; i < NCELLS; i++) begin : g_cell
		bde_cell u_cell (
			.clk       (clk),
			.clr       (accept),
			.en        (cell_en),
			.carry_in  ((i == 0) ? mag_q[bde_pkg::VALUE_W-1] : carry[(i == 0) ? 0 : i-1]),
			.carry_out (carry[i]),
			.digit     (digits[i])
		);
	end

	bde_emit #(
		.NCELLS (NCELLS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld        (ld),
		.digits    (digits),
		.busy      (emit_busy),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.digit_char >= 6'd48 && rsp.digit_char <= 6'd57))
		else $error("emitted character is not a decimal digit");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ld.load |-> !emit_busy)
		else $error("emitter loaded while still sending digits");

	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == bde_pkg::CV_RUN && step_q == '0))
		else $error("conversion did not start after an accepted item");

	a_hold_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bde_pkg::CV_RUN && step_q == STEP_LAST) |=> state_q == bde_pkg::CV_HOLD)
		else $error("conversion did not finish after the last value bit");

endmodule
`default_nettype wire

// ===== tb/tb_binary_to_decimal_digit_emitter_core.sv =====
// Testbench for binary_to_decimal_digit_emitter_core: directed and random requests with random idling.
// A scoreboard class predicts each decimal digit item and checks every digit that leaves the block.
// Depends on bde_pkg and the core module in the design folder.
`default_nettype none
module tb_binary_to_decimal_digit_emitter_core;

	localparam int TOP_DIGITS = bde_pkg::MAX_DIGITS_DEF;
	localparam logic [bde_pkg::VALUE_W-1:0] MOST_NEGATIVE =
		{1'b1, {(bde_pkg::VALUE_W-1){1'b0}}};
	localparam logic [bde_pkg::VALUE_W-1:0] ALL_ONES = {bde_pkg::VALUE_W{1'b1}};
	localparam int IDLE_PCT = 36;

	class digit_scoreboard;
		bde_pkg::rsp_item_t owed_digits[$];
		int                 errors = 0;

		task report_mismatch(string msg);
			if (errors < 20)
				$display("digit error at %0t: %s", $time, msg);
			errors++;
		endtask

		function void note_request(bde_pkg::req_item_t it);
			logic [bde_pkg::VALUE_W-1:0] magnitude;
			logic [bde_pkg::BCD_W-1:0]   decimal [TOP_DIGITS];
			bde_pkg::rsp_item_t          d;
			int                          count;
			count = int'(it.digit_count);
			if (count < 1)
				count = 1;
			if (count > TOP_DIGITS)
				count = TOP_DIGITS;
			magnitude = it.value;
			if (it.signed_mode && it.value[bde_pkg::VALUE_W-1]) begin
				magnitude = -it.value;
				if (it.value == MOST_NEGATIVE)
					count = bde_pkg::MIN_NEG_DIGITS;
			end
			for (int k = 0; k < TOP_DIGITS; k++) begin
				decimal[k] = bde_pkg::BCD_W'(magnitude % 64'd10);
				magnitude = magnitude / 64'd10;
			end
			for (int pos = count - 1; pos >= 0; pos--) begin
				d.digit_char = bde_pkg::ASCII_ZERO + bde_pkg::CHAR_W'(decimal[pos]);
				d.last_digit = (pos == 0);
				owed_digits.push_back(d);
			end
		endfunction

		task check_digit(bde_pkg::rsp_item_t got);
			bde_pkg::rsp_item_t want;
			if (owed_digits.size() == 0) begin
				report_mismatch($sformatf("unexpected digit char %0d last %0b",
					got.digit_char, got.last_digit));
				return;
			end
			want = owed_digits.pop_front();
			if (got.digit_char !== want.digit_char)
				report_mismatch($sformatf("digit_char %0d, wanted %0d",
					got.digit_char, want.digit_char));
			if (got.last_digit !== want.last_digit)
				report_mismatch($sformatf("last_digit %0b, wanted %0b",
					got.last_digit, want.last_digit));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	bde_pkg::req_item_t req = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	bde_pkg::rsp_item_t rsp;

	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	int hold_cycles = 0;

	digit_scoreboard sb = new();

	binary_to_decimal_digit_emitter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			sb.note_request(req);
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_digit(rsp);
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				rsp_stall <= 1'b1;
				hold_cycles--;
			end else begin
				rsp_stall <= rx_gaps && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	function automatic bde_pkg::req_item_t make_request(logic [bde_pkg::VALUE_W-1:0] v,
		logic sgn, logic [bde_pkg::COUNT_W-1:0] cnt);
		bde_pkg::req_item_t it;
		it.value = v;
		it.signed_mode = sgn;
		it.digit_count = cnt;
		return it;
	endfunction

	function automatic bde_pkg::req_item_t random_request();
		bde_pkg::req_item_t          it;
		logic [bde_pkg::VALUE_W-1:0] p;
		p = 64'd1;
		case ($urandom_range(9))
			0, 1, 2, 3: it.value = {$urandom, $urandom};
			4, 5:       it.value = bde_pkg::VALUE_W'($urandom_range(99999));
			6:          it.value = -bde_pkg::VALUE_W'($urandom_range(99999));
			7, 8: begin
				repeat ($urandom_range(19)) p = p * 64'd10;
				it.value = p + bde_pkg::VALUE_W'($urandom_range(2)) - 64'd1;
			end
			default: begin
				case ($urandom_range(2))
					0: it.value = MOST_NEGATIVE;
					1: it.value = MOST_NEGATIVE + 64'd1;
					default: it.value = ALL_ONES;
				endcase
			end
		endcase
		it.signed_mode = 1'($urandom_range(1));
		if ($urandom_range(99) < 10)
			it.digit_count = bde_pkg::COUNT_W'($urandom_range(31));
		else
			it.digit_count = bde_pkg::COUNT_W'($urandom_range(TOP_DIGITS, 1));
		return it;
	endfunction

	task send_request(bde_pkg::req_item_t it);
		if (tx_gaps && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < IDLE_PCT);
		end
		req_valid <= 1'b1;
		req <= it;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_request(64'd0, 1'b0, 5'd1));
		send_request(make_request(ALL_ONES, 1'b0, 5'd20));
		send_request(make_request(ALL_ONES, 1'b0, 5'd0));
		send_request(make_request(ALL_ONES, 1'b0, 5'd31));
		send_request(make_request(ALL_ONES, 1'b1, 5'd3));
		send_request(make_request(MOST_NEGATIVE, 1'b1, 5'd1));
		send_request(make_request(MOST_NEGATIVE, 1'b1, 5'd20));
		send_request(make_request(MOST_NEGATIVE, 1'b1, 5'd31));
		send_request(make_request(MOST_NEGATIVE, 1'b0, 5'd20));
		send_request(make_request(MOST_NEGATIVE + 64'd1, 1'b1, 5'd20));
		send_request(make_request(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 5'd19));
		send_request(make_request(64'd12345, 1'b0, 5'd3));
		send_request(make_request(64'd12345, 1'b0, 5'd10));
		send_request(make_request(-64'd12345, 1'b1, 5'd5));
		send_request(make_request(-64'd12345, 1'b0, 5'd20));
		send_request(make_request(64'd10000000000000000000, 1'b0, 5'd20));
		send_request(make_request(64'd9999999999999999999, 1'b0, 5'd19));
		send_request(make_request(64'd0, 1'b1, 5'd20));
		send_request(make_request(64'd7, 1'b1, 5'd0));
		send_request(make_request(64'd987654321, 1'b1, 5'd21));

		for (int n = 0; n < 450; n++) begin
			if (n == 120)
				hold_cycles = 600;
			tx_gaps = !(n >= 300 && n < 380);
			rx_gaps = !(n >= 300 && n < 380);
			send_request(random_request());
		end
		req_valid <= 1'b0;
		@(posedge clk);

		while (sb.owed_digits.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);

		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
